[src/sorted_table_binary_search_top_defines.svh]
// Assertion macros shared by the search block.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define STBS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define STBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/stbs_pkg.sv]
package stbs_pkg;

   localparam int DATA_W   = 32;
   localparam int INDEX_W  = 10;
   localparam int LENGTH_W = 11;
   localparam int POS_W    = 10;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef struct packed {
      logic                     cmd;
      logic [INDEX_W-1:0]       entry_index;
      logic signed [DATA_W-1:0] data_value;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } rsp_type;

   typedef struct packed {
      logic write;
      logic start;
      logic step;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic range_empty;
      logic hit;
   } dp_status_type;

endpackage

[src/stbs_datapath.sv]
`include "sorted_table_binary_search_top_defines.svh"

module stbs_datapath
   import stbs_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  req_type             req_data,
   input  logic                csr_we,
   input  logic [LENGTH_W-1:0] csr_data,
   input  dp_cmd_type          dp_cmd,
   output dp_status_type       dp_status,
   output rsp_type             rsp_data
);

   localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int NW   = $clog2(TABLE_DEPTH + 1);
   localparam int LENW = (NW > LENGTH_W) ? NW : LENGTH_W;

   logic [DATA_W-1:0]   table_mem [TABLE_DEPTH];
   logic [LENGTH_W-1:0] table_length_ff;
   logic [NW-1:0]       low_ff, low_in;
   logic [NW-1:0]       hiex_ff, hiex_in;
   logic [AW-1:0]       mid_ff;
   logic [AW-1:0]       rd_addr;
   logic [DATA_W-1:0]   rdata_ff;
   logic signed [DATA_W-1:0] key_ff;
   rsp_type             rsp_ff;
   logic [NW-1:0]       len_sat;
   logic                key_less;
   logic                key_greater;
   logic                index_ok;

   function automatic logic [AW-1:0] probe_mid(input logic [NW-1:0] lo,
                                               input logic [NW-1:0] hx);
      logic [NW:0] sum;
      sum = (NW+1)'(lo) + (NW+1)'(hx) - (NW+1)'(1);
      return AW'(sum[NW:1]);
   endfunction

   always_comb begin
      if (LENW'(table_length_ff) > LENW'(TABLE_DEPTH)) begin
         len_sat = NW'(TABLE_DEPTH);
      end else begin
         len_sat = NW'(table_length_ff);
      end
   end

   assign key_less    = key_ff < $signed(rdata_ff);
   assign key_greater = key_ff > $signed(rdata_ff);
   assign index_ok    = 32'(req_data.entry_index) < TABLE_DEPTH;

   assign dp_status.range_empty = low_ff >= hiex_ff;
   assign dp_status.hit         = !key_less && !key_greater;

   always_comb begin
      low_in  = low_ff;
      hiex_in = hiex_ff;
      rd_addr = mid_ff;
      if (dp_cmd.start) begin
         low_in  = '0;
         hiex_in = len_sat;
         rd_addr = probe_mid('0, len_sat);
      end else if (dp_cmd.step) begin
         if (key_less) begin
            hiex_in = NW'(mid_ff);
         end else begin
            low_in = NW'(mid_ff) + NW'(1);
         end
         rd_addr = probe_mid(low_in, hiex_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= '0;
      end else if (csr_we) begin
         table_length_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.write && index_ok) begin
         table_mem[AW'(req_data.entry_index)] <= req_data.data_value;
      end
      rdata_ff <= table_mem[rd_addr];
      mid_ff   <= rd_addr;
      low_ff   <= low_in;
      hiex_ff  <= hiex_in;
      if (dp_cmd.start) begin
         key_ff <= req_data.data_value;
      end
      if (dp_cmd.emit) begin
         rsp_ff.found    <= !dp_status.range_empty && dp_status.hit;
         rsp_ff.position <= (!dp_status.range_empty && dp_status.hit) ?
                            POS_W'(mid_ff) : '0;
      end
   end

   assign rsp_data = rsp_ff;

   `STBS_ASSERT_SAME(a_step_nonempty, clock, reset, dp_cmd.step, low_ff < hiex_ff,
                     "Probe step taken on an empty range.")
   `STBS_ASSERT_NEXT(a_start_range, clock, reset, dp_cmd.start, low_ff == '0,
                     "Search did not open with the low bound at zero.")
   `STBS_ASSERT_SAME(a_step_mid_in_range, clock, reset, dp_cmd.step,
                     (NW'(mid_ff) >= low_ff) && (NW'(mid_ff) < hiex_ff),
                     "Probe address left the search range.")

endmodule

[src/stbs_ctrl.sv]
`include "sorted_table_binary_search_top_defines.svh"

module stbs_ctrl
   import stbs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_cmd,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output dp_cmd_type    dp_cmd,
   input  dp_status_type dp_status
);

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;
   logic      finish;

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == ST_SEARCH) && (dp_status.range_empty || dp_status.hit);

   always_comb begin
      dp_cmd.write = accept && (req_cmd == CMD_LOAD);
      dp_cmd.start = accept && (req_cmd == CMD_SEARCH);
      dp_cmd.step  = (state_ff == ST_SEARCH) && !dp_status.range_empty && !dp_status.hit;
      dp_cmd.emit  = finish && slot_free;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (dp_cmd.start) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (dp_cmd.emit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `STBS_ASSERT_SAME(a_emit_on_end, clock, reset, dp_cmd.emit,
                     dp_status.range_empty || dp_status.hit,
                     "Result emitted before the search ended.")
   `STBS_ASSERT_NEXT(a_start_enters_search, clock, reset, dp_cmd.start,
                     state_ff == ST_SEARCH,
                     "Search request did not enter the search state.")
   `STBS_ASSERT_SAME(a_result_from_search, clock, reset, $rose(rsp_valid_ff),
                     $past(state_ff) == ST_SEARCH,
                     "Result appeared without a search behind it.")

endmodule

[src/sorted_table_binary_search_top.sv]
// Channel   Ports                              Moves
// request   req_valid  req_stall  req_data     load entry or search key
// response  rsp_valid  rsp_stall  rsp_data     found flag and position
// config    csr_valid  csr_ready  csr_data     table length
//
// A load writes the addressed table entry and gives no response.
// A search stalls requests while it probes the table and until its result is registered,
// so the next request is taken only after that; each probe reads one entry through the
// single memory read port and narrows the search range around the key.
// Reset clears the control state and the table length; table entries stay undefined.
// A held response does not block loads; a finished search waits for the output register.

module sorted_table_binary_search_top
   import stbs_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LENGTH_W-1:0] csr_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_data.cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   stbs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .rsp_data  (rsp_data)
   );

endmodule

[dv/tb_sorted_table_binary_search_top.sv]
`timescale 1ns / 100ps

module tb_sorted_table_binary_search_top;
   import stbs_pkg::*;

   localparam int TABLE_DEPTH   = 1024;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   typedef enum logic [1:0] {ROW_CFG, ROW_TYPED, ROW_PREDICT} row_kind_type;

   typedef struct {
      row_kind_type             kind;
      logic                     cmd;
      logic [INDEX_W-1:0]       idx;
      logic signed [DATA_W-1:0] val;
      rsp_type                  want;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [LENGTH_W-1:0] csr_data = '0;

   logic signed [DATA_W-1:0] entry_val [TABLE_DEPTH];
   logic [LENGTH_W-1:0]      table_length = '0;
   rsp_type                  pending_results [$];
   rsp_type                  oldest;
   int                       mismatches = 0;
   int                       cycle_count = 0;
   int                       send_idle_pct = 0;
   int                       stall_pct = 0;
   int                       hold_cycles = 0;
   logic                     hold_active = 1'b0;
   event                     hold_go;

   sorted_table_binary_search_top #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      forever begin
         @(hold_go);
         hold_active = 1'b1;
         repeat (hold_cycles) @(posedge clock);
         hold_active = 1'b0;
      end
   end

   function automatic rsp_type search_table(input logic signed [DATA_W-1:0] key);
      rsp_type res;
      int      lo;
      int      hi;
      int      mid;
      res = '0;
      lo = 0;
      hi = (int'(table_length) > TABLE_DEPTH ? TABLE_DEPTH : int'(table_length)) - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (key < entry_val[mid]) begin
            hi = mid - 1;
         end else if (key > entry_val[mid]) begin
            lo = mid + 1;
         end else begin
            res.found = 1'b1;
            res.position = mid[POS_W-1:0];
            break;
         end
      end
      return res;
   endfunction

   function automatic stim_row_type mk_row(input row_kind_type kind, input logic cmd,
                                           input logic [INDEX_W-1:0] idx,
                                           input logic signed [DATA_W-1:0] val,
                                           input logic found, input logic [POS_W-1:0] pos);
      stim_row_type r;
      r.kind = kind;
      r.cmd = cmd;
      r.idx = idx;
      r.val = val;
      r.want.found = found;
      r.want.position = pos;
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response found=%0b position=%0d", $time,
                     rsp_data.found, rsp_data.position);
            mismatches++;
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_data.found !== oldest.found) begin
               $display("%0t: found mismatch, expected %0b, actual %0b", $time,
                        oldest.found, rsp_data.found);
               mismatches++;
            end
            if (rsp_data.position !== oldest.position) begin
               $display("%0t: position mismatch, expected %0d, actual %0d", $time,
                        oldest.position, rsp_data.position);
               mismatches++;
            end
         end
      end
      if (hold_active) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic issue_request(input logic cmd, input logic [INDEX_W-1:0] idx,
                                input logic signed [DATA_W-1:0] val, input bit typed,
                                input rsp_type want);
      req_type r;
      r.cmd = cmd;
      r.entry_index = idx;
      r.data_value = val;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (cmd == CMD_LOAD) begin
         entry_val[idx] = val;
      end else begin
         pending_results.push_back(typed ? want : search_table(val));
      end
   endtask

   task automatic write_length(input logic [LENGTH_W-1:0] len);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      table_length = len;
   endtask

   task automatic random_phase(input logic [LENGTH_W-1:0] len, input int count,
                               input int hold);
      int                       eff;
      int                       k;
      int                       pick;
      longint                   lo_b;
      longint                   hi_b;
      logic [31:0]              span32;
      logic signed [DATA_W-1:0] v;
      write_length(len);
      hold_cycles = hold;
      if (hold > 0) begin
         -> hold_go;
      end
      eff = int'(len) > TABLE_DEPTH ? TABLE_DEPTH : int'(len);
      for (int n = 0; n < count; n++) begin
         if (hold == 0 && $urandom_range(0, 99) < 30) begin
            k = $urandom_range(0, TABLE_DEPTH - 1);
            lo_b = (k == 0) ? longint'(KEY_MIN) : longint'(entry_val[k-1]);
            hi_b = (k == TABLE_DEPTH - 1) ? longint'(KEY_MAX) : longint'(entry_val[k+1]);
            if ($urandom_range(0, 9) == 0 || lo_b > hi_b) begin
               v = $urandom;
            end else begin
               span32 = 32'(hi_b - lo_b);
               v = DATA_W'(lo_b + longint'($urandom_range(0, span32)));
            end
            issue_request(CMD_LOAD, k[INDEX_W-1:0], v, 1'b0, '0);
         end else begin
            pick = $urandom_range(0, 99);
            k = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
            if (pick < 50 && eff > 0) begin
               v = entry_val[k];
            end else if (pick < 70 && eff > 0) begin
               v = entry_val[k] + ($urandom_range(0, 1) ? 1 : -1);
            end else if (pick < 85) begin
               v = $urandom;
            end else begin
               v = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
            end
            issue_request(CMD_SEARCH, INDEX_W'($urandom), v, 1'b0, '0);
         end
      end
   endtask

   initial begin
      stim_row_type             steps [$];
      longint                   fill_val;
      logic signed [DATA_W-1:0] prev_val;
      int                       idle_mode [4][2];
      logic [LENGTH_W-1:0]      phase_len [8];

      idle_mode = '{'{0, 0}, '{76, 0}, '{0, 76}, '{28, 28}};
      phase_len = '{11'd2047, 11'd1024, 11'd1, 11'd0, 11'd2, 11'd3, 11'd1023, 11'd0};
      phase_len[7] = LENGTH_W'($urandom_range(1, TABLE_DEPTH));

      steps.push_back(mk_row(ROW_TYPED, CMD_SEARCH, 10'd0, 32'sd0, 1'b0, 10'd0));
      steps.push_back(mk_row(ROW_PREDICT, CMD_LOAD, 10'd0, KEY_MIN, 1'b0, 10'd0));
      steps.push_back(mk_row(ROW_PREDICT, CMD_LOAD, 10'd1, -32'sd5, 1'b0, 10'd0));
      steps.push_back(mk_row(ROW_PREDICT, CMD_LOAD, 10'd2, 32'sd0, 1'b0, 10'd0));
      steps.push_back(mk_row(ROW_PREDICT, CMD_LOAD, 10'd3, 32'sd7, 1'b0, 10'd0));
      steps.push_back(mk_row(ROW_PREDICT, CMD_LOAD, 10'd4, KEY_MAX, 1'b0, 10'd0));
      steps.push_back(mk_row(ROW_PREDICT, CMD_LOAD, 10'd1023, 32'sd42, 1'b0, 10'd0));
      steps.push_back(mk_row(ROW_CFG, CMD_LOAD, 10'd0, 32'sd5, 1'b0, 10'd0));
      steps.push_back(mk_row(ROW_TYPED, CMD_SEARCH, 10'd1023, KEY_MIN, 1'b1, 10'd0));
      steps.push_back(mk_row(ROW_TYPED, CMD_SEARCH, 10'd0, KEY_MAX, 1'b1, 10'd4));
      steps.push_back(mk_row(ROW_TYPED, CMD_SEARCH, 10'd5, 32'sd0, 1'b1, 10'd2));
      steps.push_back(mk_row(ROW_TYPED, CMD_SEARCH, 10'd0, 32'sd7, 1'b1, 10'd3));
      steps.push_back(mk_row(ROW_TYPED, CMD_SEARCH, 10'd0, -32'sd5, 1'b1, 10'd1));
      steps.push_back(mk_row(ROW_TYPED, CMD_SEARCH, 10'd0, 32'sd3, 1'b0, 10'd0));
      steps.push_back(mk_row(ROW_TYPED, CMD_SEARCH, 10'd0, KEY_MAX - 1, 1'b0, 10'd0));
      steps.push_back(mk_row(ROW_CFG, CMD_LOAD, 10'd0, 32'sd1, 1'b0, 10'd0));
      steps.push_back(mk_row(ROW_TYPED, CMD_SEARCH, 10'd0, KEY_MIN, 1'b1, 10'd0));
      steps.push_back(mk_row(ROW_TYPED, CMD_SEARCH, 10'd0, 32'sd1, 1'b0, 10'd0));
      steps.push_back(mk_row(ROW_CFG, CMD_LOAD, 10'd0, 32'sd5, 1'b0, 10'd0));
      steps.push_back(mk_row(ROW_PREDICT, CMD_LOAD, 10'd2, 32'sd100, 1'b0, 10'd0));
      steps.push_back(mk_row(ROW_TYPED, CMD_SEARCH, 10'd0, 32'sd7, 1'b0, 10'd0));
      steps.push_back(mk_row(ROW_TYPED, CMD_SEARCH, 10'd0, 32'sd100, 1'b1, 10'd2));
      steps.push_back(mk_row(ROW_PREDICT, CMD_SEARCH, 10'd0, -32'sd5, 1'b0, 10'd0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 28;
      stall_pct = 28;
      foreach (steps[i]) begin
         case (steps[i].kind)
            ROW_CFG: begin
               write_length(steps[i].val[LENGTH_W-1:0]);
            end
            ROW_TYPED: begin
               issue_request(steps[i].cmd, steps[i].idx, steps[i].val, 1'b1, steps[i].want);
            end
            default: begin
               issue_request(steps[i].cmd, steps[i].idx, steps[i].val, 1'b0, '0);
            end
         endcase
      end

      // The whole table is loaded in ascending order, with some repeated values.
      prev_val = KEY_MIN;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         fill_val = longint'(KEY_MIN) + (longint'(i) << 22)
                    + longint'($urandom_range(0, 4194303));
         if (i > 0 && $urandom_range(0, 7) == 0) begin
            fill_val = longint'(prev_val);
         end
         prev_val = DATA_W'(fill_val);
         issue_request(CMD_LOAD, i[INDEX_W-1:0], prev_val, 1'b0, '0);
      end

      for (int p = 0; p < 8; p++) begin
         send_idle_pct = idle_mode[p % 4][0];
         stall_pct = idle_mode[p % 4][1];
         random_phase(phase_len[p], 20, 0);
      end

      // The response side holds off long enough for the block to back up.
      send_idle_pct = 0;
      stall_pct = 0;
      random_phase(11'd1024, 40, 400);

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
